// ===== rtl/core/length_marked_frame_checker_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the length-marked frame checker
// Shared helpers that clock on clk and are disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LENGTH_MARKED_FRAME_CHECKER_ASSERT_SVH
`define LENGTH_MARKED_FRAME_CHECKER_ASSERT_SVH

// Same-cycle implication.
`define LMFC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LMFC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/lmfc_pkg.sv =====
// ----------------------------------------------------------------------------
// lmfc_pkg
// Constants and types shared by the length-marked frame checker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lmfc_pkg;

	localparam int unsigned POS_BITS = 16;
	localparam logic [31:0] POS_MAX = 32'((64'd1 << POS_BITS) - 64'd1);

	localparam logic [7:0] MARK_HEAD_A = 8'hDD;
	localparam logic [7:0] MARK_HEAD_B = 8'hEE;
	localparam logic [7:0] MARK_TAIL_A = 8'h55;
	localparam logic [7:0] MARK_TAIL_B = 8'h99;

	localparam logic [31:0] MIN_FRAME_LEN = 32'd9;
	localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_BAD_MARKER  = 2'd1;
	localparam logic [1:0] ST_BAD_LENGTH  = 2'd2;
	localparam logic [1:0] ST_BAD_TRAILER = 2'd3;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       payload_valid;
		logic       last_payload;
		logic       frame_done;
		logic [1:0] status;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/core/lmfc_in_stage.sv =====
// ----------------------------------------------------------------------------
// lmfc_in_stage
// Input register: holds one accepted byte until the parser consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lmfc_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,
	input  wire logic       take,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/lmfc_parser.sv =====
// ----------------------------------------------------------------------------
// lmfc_parser
// Frame state and per-byte decision: length, markers, payload and trailer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "length_marked_frame_checker_assert.svh"

module lmfc_parser (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wen,
	input  wire logic [15:0]       cfg_wdata,
	input  wire logic              step,
	input  wire logic [7:0]        byte_s1,
	output logic                   res_valid,
	output lmfc_pkg::result_t      res
);

	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_PAYLOAD = 2'd1;
	localparam logic [1:0] PH_TRAILER = 2'd2;

	logic [15:0]                   max_len_q;
	logic [1:0]                    phase_q, phase_d;
	logic [lmfc_pkg::POS_BITS-1:0] pos_q, pos_d;
	logic [31:0]                   len_q, len_d;
	logic                          mark_q, mark_d;
	logic                          hit;

	always_comb begin
		logic [lmfc_pkg::POS_BITS-1:0] pos_h;
		logic [31:0]                   len_h;
		logic                          mark_h;
		logic                          fin;
		logic [1:0]                    fin_st;
		logic [31:0]                   pos_w;

		phase_d = phase_q;
		pos_d   = pos_q + 1'b1;
		len_d   = len_q;
		mark_d  = mark_q;
		hit     = 1'b0;
		res     = '0;
		fin     = 1'b0;
		fin_st  = lmfc_pkg::ST_OK;
		pos_w   = 32'(pos_q);
		pos_h   = (phase_q == PH_HEADER) ? pos_q : '0;
		len_h   = (phase_q == PH_HEADER) ? len_q : '0;
		mark_h  = (phase_q == PH_HEADER) ? mark_q : 1'b0;

		case (phase_q)
			PH_PAYLOAD: begin
				hit               = 1'b1;
				res.out_byte      = byte_s1;
				res.payload_valid = 1'b1;
				res.last_payload  = (pos_w == len_q - 32'd3);
				if (res.last_payload) begin
					phase_d = PH_TRAILER;
				end
			end
			PH_TRAILER: begin
				if (pos_w == len_q - 32'd2) begin
					mark_d = (byte_s1 == lmfc_pkg::MARK_TAIL_A);
				end else begin
					fin    = 1'b1;
					fin_st = (mark_q && byte_s1 == lmfc_pkg::MARK_TAIL_B) ?
						lmfc_pkg::ST_OK : lmfc_pkg::ST_BAD_TRAILER;
				end
			end
			default: begin
				phase_d = PH_HEADER;
				pos_d   = pos_h + 1'b1;
				len_d   = len_h;
				mark_d  = mark_h;
				if (pos_h == '0) begin
					len_d = 32'(byte_s1);
				end else if (32'(pos_h) < 32'd4) begin
					len_d = {len_h[23:0], byte_s1};
				end else if (32'(pos_h) == 32'd4) begin
					mark_d = (byte_s1 == lmfc_pkg::MARK_HEAD_A);
				end else if (!mark_h || byte_s1 != lmfc_pkg::MARK_HEAD_B) begin
					fin    = 1'b1;
					fin_st = lmfc_pkg::ST_BAD_MARKER;
				end else if (len_h < lmfc_pkg::MIN_FRAME_LEN
					|| len_h > 32'(max_len_q) || len_h > lmfc_pkg::POS_MAX) begin
					fin    = 1'b1;
					fin_st = lmfc_pkg::ST_BAD_LENGTH;
				end else begin
					phase_d = PH_PAYLOAD;
					mark_d  = 1'b0;
				end
			end
		endcase

		if (fin) begin
			hit            = 1'b1;
			res            = '0;
			res.frame_done = 1'b1;
			res.status     = fin_st;
			phase_d        = PH_HEADER;
			pos_d          = '0;
			len_d          = '0;
			mark_d         = 1'b0;
		end
	end

	assign res_valid = step && hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= lmfc_pkg::MAX_LEN_RESET;
			phase_q   <= PH_HEADER;
			pos_q     <= '0;
			len_q     <= '0;
			mark_q    <= 1'b0;
		end else begin
			if (cfg_wen) begin
				max_len_q <= cfg_wdata;
			end
			if (step) begin
				phase_q <= phase_d;
				pos_q   <= pos_d;
				len_q   <= len_d;
				mark_q  <= mark_d;
			end
		end
	end

	`LMFC_ASSERT_NOW(a_kind_excl, res_valid, !(res.payload_valid && res.frame_done), "payload and done together")
	`LMFC_ASSERT_NOW(a_len_sane, phase_q == PH_PAYLOAD, len_q >= lmfc_pkg::MIN_FRAME_LEN && len_q <= lmfc_pkg::POS_MAX, "payload with bad length")
	`LMFC_ASSERT_NOW(a_pay_pos, phase_q == PH_PAYLOAD, 32'(pos_q) >= 32'd6 && 32'(pos_q) <= len_q - 32'd3, "payload position out of frame")
	`LMFC_ASSERT_NOW(a_trl_pos, phase_q == PH_TRAILER, 32'(pos_q) == len_q - 32'd2 || 32'(pos_q) == len_q - 32'd1, "trailer position out of frame")
	`LMFC_ASSERT_NXT(a_last_trl, res_valid && res.last_payload, phase_q == PH_TRAILER, "last payload not followed by trailer")

endmodule

`default_nettype wire

// ===== rtl/core/lmfc_out_stage.sv =====
// ----------------------------------------------------------------------------
// lmfc_out_stage
// Output register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lmfc_out_stage (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               res_valid,
	input  wire lmfc_pkg::result_t  res,
	output logic                    ready,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output lmfc_pkg::result_t       out_q
);

	assign ready = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (ready) begin
			m_tvalid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && res_valid) begin
			out_q <= res;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/length_marked_frame_checker.sv =====
// ----------------------------------------------------------------------------
// length_marked_frame_checker
// Byte-stream deframer for length-prefixed frames with header and trailer.
// ----------------------------------------------------------------------------
// The s_ channel takes one raw byte per transfer. A frame is a 4-byte
// big-endian total length, the header DD EE, one or more payload bytes and
// the trailer 55 99. The m_ channel gives one transfer per payload byte, with
// m_tlast on the last one, and one done transfer per frame that carries the
// status: ok, bad header marker, bad length or bad trailer. Length bytes,
// first marker bytes and the EE of a good header give no transfer.
// An input byte is decided while it sits in the input register, and its
// result goes into the output register, which holds it for the receiver.
// One byte is taken every cycle while the receiver keeps up; the output
// register decouples the sides for a single result.
// When m_tready is low with a result waiting, the parser holds and s_tready
// drops once the input register is full; nothing is lost or repeated.
// Reset clears the frame state, sets max_frame_len to 1024 and empties both
// registers. cfg_wen writes max_frame_len; write it only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module length_marked_frame_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic [15:0] cfg_wdata,   // max_frame_len
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,     // in_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,     // out_byte
	output logic             m_tlast,     // last_payload
	output logic [3:0]       m_tuser      // {status[1:0], frame_done, payload_valid}
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              out_ready;
	logic              res_valid;
	lmfc_pkg::result_t res;
	lmfc_pkg::result_t out_q;

	lmfc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.take     (out_ready),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	lmfc_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.step      (valid_s1 && out_ready),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	lmfc_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.ready     (out_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.out_q     (out_q)
	);

	assign m_tdata = out_q.out_byte;
	assign m_tlast = out_q.last_payload;
	assign m_tuser = {out_q.status, out_q.frame_done, out_q.payload_valid};

endmodule

`default_nettype wire
